### src/rde_pkg.sv
// shared constants and types for the radix digit expander
package rde_pkg;

  localparam int VALUE_WIDTH = 64;
  localparam int CNT_W       = $clog2(VALUE_WIDTH);
  localparam int IN_W        = 64;
  localparam int RADIX_W     = 8;
  localparam int DIGIT_W     = 8;
  localparam int POS_W       = 6;
  localparam int TERM_W      = 64;
  localparam int MCNT_W      = $clog2(RADIX_W);
  localparam int ADDR_W      = 2;
  localparam int DATA_W      = 32;

  typedef logic [VALUE_WIDTH-1:0] val_t;
  typedef logic [IN_W-1:0]        in_val_t;
  typedef logic [RADIX_W-1:0]     radix_t;
  typedef logic [DIGIT_W-1:0]     digit_t;
  typedef logic [POS_W-1:0]       pos_t;
  typedef logic [TERM_W-1:0]      term_t;
  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [DATA_W-1:0]      data_t;

  localparam addr_t  RADIX_ADDR  = addr_t'(0);
  localparam radix_t RADIX_RESET = radix_t'(10);
  localparam radix_t RADIX_MIN   = radix_t'(2);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DRAIN
  } rde_state_t;

endpackage

### src/rde_in_if.sv
// input channel: one number to expand per item
interface rde_in_if;
  import rde_pkg::*;

  logic    valid;
  logic    ready;
  in_val_t value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

### src/rde_out_if.sv
// result channel: one digit with its position and term per item
interface rde_out_if;
  import rde_pkg::*;

  logic   valid;
  logic   ready;
  digit_t digit;
  pos_t   position;
  term_t  term;
  logic   final_res;

  modport source (output valid, output digit, output position, output term,
                  output final_res, input ready);
  modport sink   (input valid, input digit, input position, input term,
                  input final_res, output ready);
endinterface

### src/radix_digit_expander.sv
// top level: expands a number into its base-radix digits, least significant first
//
//   channel   dir   handshake              payload
//   in_ch     in    valid/ready            value
//   out_ch    out   valid/ready            digit, position, term, final_res
//   cfg_*     in    apb, pready always 1   radix at byte address 0
//
// each digit comes from the bit-serial restoring divider, one quotient bit
// per cycle, though the last bit waits while the multiplier is busy; the term
// and the next weight come from an 8-step shift-add multiplier that runs while
// the next division goes on. an item yields at most 64 digits; the next item
// is taken once the last term is built and loaded into the output register.
// reset sets radix to 10 and empties the pipeline; there is no clearing pass.
// a stalled output holds the multiplier, which in turn holds the end of the
// following division, so nothing is lost or dropped.
module radix_digit_expander (
  input  logic                 clk,
  input  logic                 rst_n,
  rde_in_if.sink               in_ch,
  rde_out_if.source            out_ch,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  rde_pkg::addr_t       cfg_paddr,
  input  rde_pkg::data_t       cfg_pwdata,
  output rde_pkg::data_t       cfg_prdata,
  output logic                 cfg_pready
);
  import rde_pkg::*;

  // control state
  rde_state_t state_r, state_nxt;
  radix_t     radix_r, radix_nxt;
  logic [CNT_W-1:0]  dcnt_r, dcnt_nxt;
  logic              mbusy_r, mbusy_nxt;
  logic              mhold_r, mhold_nxt;
  logic [MCNT_W-1:0] mcnt_r, mcnt_nxt;
  logic              ovalid_r, ovalid_nxt;

  // divider datapath: rest shifts out dividend bits and takes in quotient bits
  val_t   rest_r, rest_nxt;
  radix_t rem_r, rem_nxt;
  pos_t   pos_r, pos_nxt;
  val_t   wgt_r, wgt_nxt;

  // multiplier datapath
  digit_t md_r, md_nxt;
  digit_t dsh_r, dsh_nxt;
  radix_t bsh_r, bsh_nxt;
  val_t   msh_r, msh_nxt;
  val_t   mterm_r, mterm_nxt;
  val_t   mwnx_r, mwnx_nxt;
  pos_t   mpos_r, mpos_nxt;
  logic   mfin_r, mfin_nxt;

  // output register
  digit_t odigit_r, odigit_nxt;
  pos_t   opos_r, opos_nxt;
  val_t   oterm_r, oterm_nxt;
  logic   ofin_r, ofin_nxt;

  radix_t           base;
  logic [RADIX_W:0] trial;
  logic [RADIX_W:0] diff;
  logic             ge;
  radix_t           rem_step;
  val_t             q_step;
  logic             fin;
  logic             out_free;
  logic             cfg_wr;

  // radix 0 or 1 would never terminate, run those as radix 2
  assign base = (radix_r < RADIX_MIN) ? RADIX_MIN : radix_r;

  // one restoring division step: bring down the next dividend bit
  assign trial    = {rem_r, rest_r[VALUE_WIDTH-1]};
  assign diff     = trial - {1'b0, base};
  assign ge       = trial >= {1'b0, base};
  assign rem_step = ge ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
  assign q_step   = {rest_r[VALUE_WIDTH-2:0], ge};

  // last digit when the quotient runs out or all positions are used
  assign fin      = (q_step == '0) || (pos_r == '1);
  assign out_free = !ovalid_r || out_ch.ready;

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == RADIX_ADDR);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == RADIX_ADDR) ? data_t'(radix_r) : '0;

  assign in_ch.ready      = (state_r == ST_IDLE);
  assign out_ch.valid     = ovalid_r;
  assign out_ch.digit     = odigit_r;
  assign out_ch.position  = opos_r;
  assign out_ch.term      = term_t'(oterm_r);
  assign out_ch.final_res = ofin_r;

  always_comb begin
    state_nxt  = state_r;
    radix_nxt  = radix_r;
    dcnt_nxt   = dcnt_r;
    mbusy_nxt  = mbusy_r;
    mhold_nxt  = mhold_r;
    mcnt_nxt   = mcnt_r;
    ovalid_nxt = ovalid_r;
    rest_nxt   = rest_r;
    rem_nxt    = rem_r;
    pos_nxt    = pos_r;
    wgt_nxt    = wgt_r;
    md_nxt     = md_r;
    dsh_nxt    = dsh_r;
    bsh_nxt    = bsh_r;
    msh_nxt    = msh_r;
    mterm_nxt  = mterm_r;
    mwnx_nxt   = mwnx_r;
    mpos_nxt   = mpos_r;
    mfin_nxt   = mfin_r;
    odigit_nxt = odigit_r;
    opos_nxt   = opos_r;
    oterm_nxt  = oterm_r;
    ofin_nxt   = ofin_r;

    if (cfg_wr) begin
      radix_nxt = cfg_pwdata[RADIX_W-1:0];
    end

    // result taken downstream
    if (out_ch.ready) begin
      ovalid_nxt = 1'b0;
    end

    // shift-add multiplier: term = digit * weight, next weight = weight * base
    if (mbusy_r && !mhold_r) begin
      if (dsh_r[0]) begin
        mterm_nxt = mterm_r + msh_r;
      end
      if (bsh_r[0]) begin
        mwnx_nxt = mwnx_r + msh_r;
      end
      msh_nxt  = msh_r << 1;
      dsh_nxt  = dsh_r >> 1;
      bsh_nxt  = bsh_r >> 1;
      mcnt_nxt = mcnt_r + 1'b1;
      if (mcnt_r == '1) begin
        mhold_nxt = 1'b1;
      end
    end else if (mbusy_r && mhold_r && out_free) begin
      ovalid_nxt = 1'b1;
      odigit_nxt = md_r;
      opos_nxt   = mpos_r;
      oterm_nxt  = mterm_r;
      ofin_nxt   = mfin_r;
      wgt_nxt    = mwnx_r;
      mbusy_nxt  = 1'b0;
      mhold_nxt  = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          rest_nxt  = in_ch.value[VALUE_WIDTH-1:0];
          rem_nxt   = '0;
          dcnt_nxt  = CNT_W'(VALUE_WIDTH - 1);
          pos_nxt   = '0;
          wgt_nxt   = val_t'(1);
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (dcnt_r != '0) begin
          rest_nxt = q_step;
          rem_nxt  = rem_step;
          dcnt_nxt = dcnt_r - 1'b1;
        end else if (!mbusy_r) begin
          // last quotient bit: hand the digit to the multiplier
          mbusy_nxt = 1'b1;
          mhold_nxt = 1'b0;
          mcnt_nxt  = '0;
          md_nxt    = rem_step;
          dsh_nxt   = rem_step;
          bsh_nxt   = base;
          msh_nxt   = wgt_r;
          mterm_nxt = '0;
          mwnx_nxt  = '0;
          mpos_nxt  = pos_r;
          mfin_nxt  = fin;
          if (fin) begin
            state_nxt = ST_DRAIN;
          end else begin
            rest_nxt = q_step;
            rem_nxt  = '0;
            dcnt_nxt = CNT_W'(VALUE_WIDTH - 1);
            pos_nxt  = pos_r + 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        if (!mbusy_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      radix_r  <= RADIX_RESET;
      dcnt_r   <= '0;
      mbusy_r  <= 1'b0;
      mhold_r  <= 1'b0;
      mcnt_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      radix_r  <= radix_nxt;
      dcnt_r   <= dcnt_nxt;
      mbusy_r  <= mbusy_nxt;
      mhold_r  <= mhold_nxt;
      mcnt_r   <= mcnt_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rest_r   <= rest_nxt;
    rem_r    <= rem_nxt;
    pos_r    <= pos_nxt;
    wgt_r    <= wgt_nxt;
    md_r     <= md_nxt;
    dsh_r    <= dsh_nxt;
    bsh_r    <= bsh_nxt;
    msh_r    <= msh_nxt;
    mterm_r  <= mterm_nxt;
    mwnx_r   <= mwnx_nxt;
    mpos_r   <= mpos_nxt;
    mfin_r   <= mfin_nxt;
    odigit_r <= odigit_nxt;
    opos_r   <= opos_nxt;
    oterm_r  <= oterm_nxt;
    ofin_r   <= ofin_nxt;
  end

endmodule
